/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is applied.
`define LC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds while the reset is applied.
`define LC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/lc1d_pkg.sv */
// Package with the shared types and constants of the convolution filter.
`default_nettype none

package lc1d_pkg;

   // Fixed field widths.
   localparam int DATA_W     = 32;
   localparam int TIDX_W     = 4;
   localparam int KLEN_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   // Request kinds.
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // Register index of the kernel length.
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_LEN = '0;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_RUN,
      ST_TAIL,
      ST_CLEAR
   } lc_state_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;
      logic clear;
      logic load;
      logic tap_on;
   } cell_ctrl_type;

   // Token that travels beside the data through the pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } pipe_tok_type;

   // One result beat.
   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              last_result;
   } rsp_beat_type;

endpackage

`default_nettype wire

/* hdl/lc1d_if.sv */
// Request and result channel interfaces of the convolution filter.
`default_nettype none

interface lc1d_req_if;
   import lc1d_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [TIDX_W-1:0]        tap_index;
   logic signed [DATA_W-1:0] coeff_value;
   logic signed [DATA_W-1:0] sample_value;
   logic                     last_sample;

   modport source (
      output valid, req_type, tap_index, coeff_value, sample_value, last_sample,
      input  ready
   );

   modport sink (
      input  valid, req_type, tap_index, coeff_value, sample_value, last_sample,
      output ready
   );
endinterface

interface lc1d_rsp_if;
   import lc1d_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic                     last_result;

   modport source (
      output valid, result_value, last_result,
      input  ready
   );

   modport sink (
      input  valid, result_value, last_result,
      output ready
   );
endinterface

`default_nettype wire

/* hdl/lc1d_cell.sv */
// One filter cell: a history sample, its coefficient and a registered product.
`default_nettype none

module lc1d_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  lc1d_pkg::cell_ctrl_type       ctrl,
   input  logic [lc1d_pkg::DATA_W-1:0]   sample_in,
   input  logic [lc1d_pkg::DATA_W-1:0]   coeff_in,
   output logic [lc1d_pkg::DATA_W-1:0]   sample_out,
   output logic [lc1d_pkg::DATA_W-1:0]   product_out
);
   import lc1d_pkg::*;

   logic [DATA_W-1:0]   sample_ff;
   logic [DATA_W-1:0]   coeff_ff;
   logic [DATA_W-1:0]   product_ff;
   logic [2*DATA_W-1:0] full_product;

   // Sample slot of the delay line; it shifts toward the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (ctrl.clear) begin
         sample_ff <= '0;
      end else if (ctrl.shift) begin
         sample_ff <= sample_in;
      end
   end

   // Coefficient of this tap, written by a load beat.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         coeff_ff <= coeff_in;
      end
   end

   // The low half of the product is the same for signed and unsigned operands.
   assign full_product = coeff_ff * sample_ff;

   // Taps past the kernel length contribute nothing.
   always_ff @(posedge clock) begin
      product_ff <= ctrl.tap_on ? full_product[DATA_W-1:0] : '0;
   end

   assign sample_out  = sample_ff;
   assign product_out = product_ff;

endmodule

`default_nettype wire

/* hdl/lc1d_sum_tree.sv */
// Registered adder tree that sums the tap products, with a register at each level.
`default_nettype none

module lc1d_sum_tree #(
   parameter int NUM_IN = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lc1d_pkg::DATA_W-1:0]  prod_in [NUM_IN],
   input  lc1d_pkg::pipe_tok_type       tok_in,
   output logic [lc1d_pkg::DATA_W-1:0]  sum_out,
   output lc1d_pkg::pipe_tok_type       tok_out
);
   import lc1d_pkg::*;

   localparam int LEVELS = (NUM_IN > 1) ? $clog2(NUM_IN) : 0;
   localparam int WIDTH  = 2 ** LEVELS;

   logic [DATA_W-1:0] node [LEVELS+1][WIDTH];
   pipe_tok_type      tok  [LEVELS+1];

   // Leaves: the products, padded with zeros up to a power of two.
   for (genvar i = 0; i < WIDTH; i++) begin : g_leaf
      if (i < NUM_IN) begin : g_used
         assign node[0][i] = prod_in[i];
      end else begin : g_pad
         assign node[0][i] = '0;
      end
   end

   assign tok[0] = tok_in;

   // Each level adds pairs and registers the sums; sums wrap at 32 bits.
   for (genvar l = 0; l < LEVELS; l++) begin : g_level
      for (genvar i = 0; i < WIDTH; i++) begin : g_node
         if (i < (WIDTH >> (l + 1))) begin : g_add
            always_ff @(posedge clock) begin
               node[l+1][i] <= node[l][2*i] + node[l][2*i+1];
            end
         end else begin : g_idle
            assign node[l+1][i] = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tok[l+1] <= '0;
         end else begin
            tok[l+1] <= tok[l];
         end
      end
   end

   assign sum_out = node[LEVELS][0];
   assign tok_out = tok[LEVELS];

endmodule

`default_nettype wire

/* hdl/lc1d_rsp_fifo.sv */
// Result buffer with a registered output stage that drives the result channel.
`default_nettype none

module lc1d_rsp_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  lc1d_pkg::rsp_beat_type wr_data,
   lc1d_rsp_if.source             rsp
);
   import lc1d_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_beat_type     mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             out_valid_ff;
   rsp_beat_type     out_data_ff;
   logic             mem_empty;
   logic             load_out;
   logic             mem_wr;
   logic             mem_rd;

   // The output stage refills whenever it is empty or its beat is taken.
   assign mem_empty = (count_ff == '0);
   assign load_out  = !out_valid_ff || rsp.ready;
   assign mem_rd    = load_out && !mem_empty;
   assign mem_wr    = wr_en && !(load_out && mem_empty);

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (mem_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (mem_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(mem_wr) - CNT_W'(mem_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage write.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   // Output register: oldest stored beat first, else the incoming beat directly.
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_data_ff <= mem_empty ? wr_data : mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= !mem_empty || wr_en;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.result_value = out_data_ff.result_value;
   assign rsp.last_result  = out_data_ff.last_result;

endmodule

`default_nettype wire

/* hdl/linear_convolution_1d.sv */
// Top level of the streaming direct-form FIR that computes full linear convolution.
`default_nettype none

// Streaming FIR over a row of MAX_TAPS cells. Each cell holds one coefficient and
// one sample of the delay line, and registers its product; a registered adder
// tree of clog2(MAX_TAPS) levels sums the products. A coefficient load or a
// sample is taken every clock in steady state; a sample's result passes its sample
// slot, the product register, the tree levels and the result buffer's output
// register on its way to rsp_bus. A sample marked last_sample is followed by one
// flush step per tap in use past the first, which shift zeros into the cells and
// produce the tail results, and one step that clears the delay line; no request
// is taken during those steps. The result buffer holds the pipeline depth rounded
// up to a power of two, and outside the flush requests stall only when it is full
// because the result side is not taking beats. The kernel length register sits at
// byte address 0 of the csr port; write it only while no request is in progress.
// Coefficients must be loaded before they are used.
module linear_convolution_1d #(
   parameter int MAX_TAPS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   lc1d_req_if.sink                          req_bus,
   lc1d_rsp_if.source                        rsp_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lc1d_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [lc1d_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [lc1d_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import lc1d_pkg::*;

   localparam int LEVELS     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0;
   localparam int LATENCY    = LEVELS + 3;
   localparam int FIFO_DEPTH = 2 ** $clog2(LATENCY);
   localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

   logic [KLEN_W-1:0]    kernel_len_ff;
   logic [KLEN_W-1:0]    taps;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   lc_state_type         state_ff, state_in;
   logic [KLEN_W-1:0]    tail_cnt_ff, tail_cnt_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   pipe_tok_type         tok0_ff, tok1_ff;

   logic                 credit_ok;
   logic                 req_ready;
   logic                 req_fire;
   logic                 load_fire;
   logic                 rsp_fire;
   logic                 shift;
   logic                 shift_zero;
   logic                 clear;
   logic                 issue;
   logic                 issue_last;

   logic [DATA_W-1:0]    chain   [MAX_TAPS];
   logic [DATA_W-1:0]    product [MAX_TAPS];
   logic [DATA_W-1:0]    head_sample;
   logic [DATA_W-1:0]    sum;
   pipe_tok_type         sum_tok;
   rsp_beat_type         fifo_data;

   // Register port: single kernel length register; pready is tied high.
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_idx == CSR_KERNEL_LEN) ? CSR_DATA_W'(kernel_len_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_len_ff <= KLEN_W'(1);
      end else if (csr_wr && (csr_idx == CSR_KERNEL_LEN)) begin
         kernel_len_ff <= csr_pwdata[KLEN_W-1:0];
      end
   end

   // Taps in use: a zero length counts as one, a long one is capped at MAX_TAPS.
   always_comb begin
      if (kernel_len_ff == '0) begin
         taps = KLEN_W'(1);
      end else if (32'(kernel_len_ff) > MAX_TAPS) begin
         taps = KLEN_W'(MAX_TAPS);
      end else begin
         taps = kernel_len_ff;
      end
   end

   // Handshakes; a beat is issued only while the result buffer has room for it.
   assign credit_ok     = (occ_ff < OCC_W'(FIFO_DEPTH));
   assign req_ready     = (state_ff == ST_RUN) && credit_ok;
   assign req_bus.ready = req_ready;
   assign req_fire      = req_bus.valid && req_ready;
   assign load_fire     = req_fire && (req_bus.req_type == REQ_LOAD);
   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;

   // Sequencer: streaming samples, zero flush after the last one, then clear.
   always_comb begin
      state_in    = state_ff;
      tail_cnt_in = tail_cnt_ff;
      shift       = 1'b0;
      shift_zero  = 1'b0;
      clear       = 1'b0;
      issue       = 1'b0;
      issue_last  = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (req_fire && (req_bus.req_type == REQ_SAMPLE)) begin
               shift      = 1'b1;
               issue      = 1'b1;
               issue_last = req_bus.last_sample && (taps == KLEN_W'(1));
               if (req_bus.last_sample) begin
                  if (taps == KLEN_W'(1)) begin
                     state_in = ST_CLEAR;
                  end else begin
                     state_in    = ST_TAIL;
                     tail_cnt_in = taps - KLEN_W'(1);
                  end
               end
            end
         end
         ST_TAIL: begin
            if (credit_ok) begin
               shift       = 1'b1;
               shift_zero  = 1'b1;
               issue       = 1'b1;
               issue_last  = (tail_cnt_ff == KLEN_W'(1));
               tail_cnt_in = tail_cnt_ff - KLEN_W'(1);
               if (tail_cnt_ff == KLEN_W'(1)) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            clear    = 1'b1;
            state_in = ST_RUN;
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // Results issued and not yet taken by the result side.
   assign occ_in = occ_ff + OCC_W'(issue) - OCC_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_RUN;
         tail_cnt_ff <= '0;
         occ_ff      <= '0;
         tok0_ff     <= '0;
         tok1_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         tail_cnt_ff <= tail_cnt_in;
         occ_ff      <= occ_in;
         tok0_ff     <= '{valid: issue, last: issue_last};
         tok1_ff     <= tok0_ff;
      end
   end

   // Row of cells; the first takes the new sample, or zero during the flush.
   assign head_sample = shift_zero ? '0 : DATA_W'(req_bus.sample_value);

   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [DATA_W-1:0] cell_in;

      assign ctrl.shift  = shift;
      assign ctrl.clear  = clear;
      assign ctrl.load   = load_fire && (32'(req_bus.tap_index) == 32'(k));
      assign ctrl.tap_on = (32'(k) < 32'(taps));

      if (k == 0) begin : g_head
         assign cell_in = head_sample;
      end else begin : g_body
         assign cell_in = chain[k-1];
      end

      lc1d_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .sample_in   (cell_in),
         .coeff_in    (DATA_W'(req_bus.coeff_value)),
         .sample_out  (chain[k]),
         .product_out (product[k])
      );
   end

   // Sum of the products.
   lc1d_sum_tree #(
      .NUM_IN (MAX_TAPS)
   ) u_sum_tree (
      .clock   (clock),
      .reset   (reset),
      .prod_in (product),
      .tok_in  (tok1_ff),
      .sum_out (sum),
      .tok_out (sum_tok)
   );

   // Result buffer toward the result channel.
   assign fifo_data = '{result_value: sum, last_result: sum_tok.last};

   lc1d_rsp_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (sum_tok.valid),
      .wr_data (fifo_data),
      .rsp     (rsp_bus)
   );

endmodule

`default_nettype wire

/* hdl/lc1d_checker.sv */
// Port-level checker for the convolution filter and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module lc1d_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_type,
   input logic                          last_sample,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lc1d_pkg::DATA_W-1:0]   rsp_result_value,
   input logic                          rsp_last_result
);
   import lc1d_pkg::*;

   // The result buffer is empty after reset.
   `LC_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "result beat right after reset")

   // A result beat that is not taken stays offered.
   `LC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result beat dropped")

   // A stalled result beat keeps its payload.
   `LC_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_result_value) && $stable(rsp_last_result), "stalled result changed")

   // The flush or the clear that follows a last sample takes no request.
   `LC_ASSERT(a_flush_blocks, clock, reset, !reset && req_valid && req_ready && (req_type == REQ_SAMPLE) && last_sample |=> !req_ready, "request taken after last sample")

endmodule

bind linear_convolution_1d lc1d_checker u_lc1d_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_type         (req_bus.req_type),
   .last_sample      (req_bus.last_sample),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_result_value (rsp_bus.result_value),
   .rsp_last_result  (rsp_bus.last_result)
);

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the streaming FIR that computes full linear convolution.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lc1d_pkg::*;

   localparam int TAPS           = 16;
   localparam int ITEM_TARGET    = 450;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 1000;

   logic clock;
   logic reset;

   lc1d_req_if req_bus ();
   lc1d_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   linear_convolution_1d #(.MAX_TAPS(TAPS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Shadow of the filter: kernel, delay line and tap count.
   logic [DATA_W-1:0] coeff_tab [TAPS];
   logic [DATA_W-1:0] delay_line [TAPS-1];
   logic [KLEN_W-1:0] kernel_len_q = KLEN_W'(1);

   // Convolution outputs still owed by the block, oldest first.
   rsp_beat_type conv_out_q [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int idle_cycles    = 0;
   bit no_idle        = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count one mismatch and describe it on one line.
   task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Taps in use: zero counts as one, anything above the store saturates.
   function automatic int taps_active();
      if (kernel_len_q == 0) return 1;
      if (kernel_len_q > TAPS) return TAPS;
      return int'(kernel_len_q);
   endfunction

   // Shift one sample into the delay line and return the wrapped dot product.
   function automatic logic [DATA_W-1:0] conv_push(logic [DATA_W-1:0] x);
      logic [DATA_W-1:0] acc;
      int                taps;
      taps = taps_active();
      acc  = coeff_tab[0] * x;
      for (int k = 1; k < taps; k++) acc += coeff_tab[k] * delay_line[k-1];
      for (int j = TAPS - 2; j >= 1; j--) delay_line[j] = delay_line[j-1];
      delay_line[0] = x;
      return acc;
   endfunction

   // A sample yields one output; a last sample also flushes the tail and clears history.
   function automatic void predict_sample(logic [DATA_W-1:0] x, logic lst);
      rsp_beat_type beat;
      int           taps;
      taps              = taps_active();
      beat.result_value = conv_push(x);
      beat.last_result  = lst && (taps == 1);
      conv_out_q.push_back(beat);
      if (lst) begin
         for (int t = 1; t < taps; t++) begin
            beat.result_value = conv_push('0);
            beat.last_result  = (t == taps - 1);
            conv_out_q.push_back(beat);
         end
         foreach (delay_line[j]) delay_line[j] = '0;
      end
   endfunction

   // Track accepted requests and check every accepted result beat.
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         if (req_bus.req_type == REQ_LOAD) coeff_tab[req_bus.tap_index] = req_bus.coeff_value;
         else predict_sample(req_bus.sample_value, req_bus.last_sample);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (conv_out_q.size() == 0) begin
            report("result beat with none pending", rsp_bus.result_value, 'x);
         end else begin
            want = conv_out_q.pop_front();
            if (rsp_bus.result_value !== want.result_value)
               report("result_value", rsp_bus.result_value, want.result_value);
            if (rsp_bus.last_result !== want.last_result)
               report("last_result", 32'(rsp_bus.last_result), 32'(want.last_result));
         end
      end
   end

   // End the run when no beat and no register access happens for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Result side: stall a random number of cycles before taking each beat.
   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // One APB transfer; psel stays high so transfers can run back to back.
   task automatic csr_access(logic wr, logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel   <= 1'b1;
      csr_pwrite <= wr;
      csr_paddr  <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_penable <= 1'b0;
   endtask

   // Write the kernel length, then read it back.
   task automatic set_kernel_len(logic [KLEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, CSR_KERNEL_LEN, CSR_DATA_W'(len), rdata);
      kernel_len_q = len;
      csr_access(1'b0, CSR_KERNEL_LEN, '0, rdata);
      csr_psel <= 1'b0;
      if (rdata !== CSR_DATA_W'(kernel_len_q))
         report("kernel_len readback", rdata, CSR_DATA_W'(kernel_len_q));
   endtask

   // Present one request beat after a random gap and hold it until it is taken.
   task automatic send_req(logic kind, logic [TIDX_W-1:0] idx, logic [DATA_W-1:0] cv,
                           logic [DATA_W-1:0] sv, logic lst);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= kind;
      req_bus.tap_index    <= idx;
      req_bus.coeff_value  <= cv;
      req_bus.sample_value <= sv;
      req_bus.last_sample  <= lst;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   // Fields that a request kind ignores carry random values.
   task automatic load_tap(logic [TIDX_W-1:0] idx, logic [DATA_W-1:0] value);
      send_req(REQ_LOAD, idx, value, $urandom(), 1'($urandom_range(0, 1)));
   endtask

   task automatic feed_sample(logic [DATA_W-1:0] value, logic lst);
      send_req(REQ_SAMPLE, TIDX_W'($urandom_range(0, TAPS - 1)), $urandom(), value, lst);
   endtask

   // Stop sending, wait for every owed output, then let the pipeline settle.
   // The first clock lets the tracker record the beat accepted at this edge.
   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (conv_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random data word biased toward the extremes and small values.
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'($urandom_range(0, 16)) - 32'd8;
         default: return $urandom();
      endcase
   endfunction

   // The length register comes out of reset at one tap.
   task automatic test_reset_length();
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, CSR_KERNEL_LEN, '0, rdata);
      csr_psel <= 1'b0;
      if (rdata !== CSR_DATA_W'(1)) report("kernel_len after reset", rdata, CSR_DATA_W'(1));
   endtask

   // One tap: extreme samples, and the last flag rides on the single output.
   task automatic test_single_tap();
      load_tap(0, 32'h8000_0000);
      feed_sample(32'h8000_0000, 1'b0);
      feed_sample(32'h7FFF_FFFF, 1'b0);
      feed_sample(32'hFFFF_FFFF, 1'b1);
      finish_phase();
   endtask

   // Load taps 1 to 4 with extremes and the others above 0 with random words, then run a full-length kernel.
   task automatic test_full_kernel();
      for (int i = 1; i < TAPS; i++) begin
         case (i)
            1: load_tap(TIDX_W'(i), 32'h7FFF_FFFF);
            2: load_tap(TIDX_W'(i), 32'h8000_0000);
            3: load_tap(TIDX_W'(i), 32'hFFFF_FFFF);
            4: load_tap(TIDX_W'(i), 32'h0000_0001);
            default: load_tap(TIDX_W'(i), pick_word());
         endcase
      end
      finish_phase();
      set_kernel_len(KLEN_W'(TAPS));
      feed_sample(32'h7FFF_FFFF, 1'b0);
      feed_sample(32'h8000_0000, 1'b1);
      finish_phase();
   endtask

   // A length of zero acts as one tap; an oversized length saturates.
   task automatic test_length_limits();
      set_kernel_len('0);
      feed_sample(pick_word(), 1'b0);
      feed_sample(pick_word(), 1'b1);
      finish_phase();
      set_kernel_len('1);
      feed_sample(pick_word(), 1'b1);
      finish_phase();
   endtask

   // A new length takes effect on the next sample; history survives the change.
   task automatic test_length_change_mid_sequence();
      set_kernel_len(5'd3);
      for (int i = 0; i < 3; i++) feed_sample(pick_word(), 1'b0);
      finish_phase();
      set_kernel_len(5'd7);
      feed_sample(pick_word(), 1'b0);
      feed_sample(pick_word(), 1'b1);
      finish_phase();
   endtask

   // Phases of random sequences, each under a freshly chosen kernel length.
   task automatic test_random_sequences();
      logic [KLEN_W-1:0] len;
      int                n_seqs;
      int                seq_len;
      logic              lst;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: len = '0;
            1: len = '1;
            2: len = 5'd1;
            3: len = KLEN_W'(TAPS);
            4: len = KLEN_W'($urandom_range(TAPS + 1, 31));
            default: len = KLEN_W'($urandom_range(1, TAPS));
         endcase
         set_kernel_len(len);
         no_idle = ($urandom_range(0, 3) == 0);
         n_seqs  = $urandom_range(1, 4);
         for (int s = 0; s < n_seqs; s++) begin
            seq_len = $urandom_range(1, 12);
            for (int i = 0; i < seq_len; i++) begin
               // Occasional coefficient reloads land in the middle of a sequence.
               if ($urandom_range(0, 7) == 0)
                  load_tap(TIDX_W'($urandom_range(0, TAPS - 1)), pick_word());
               // Now and then a sequence runs on without its last flag.
               lst = (i == seq_len - 1) && ($urandom_range(0, 7) != 0);
               feed_sample(pick_word(), lst);
            end
         end
         finish_phase();
      end
      no_idle = 0;
   endtask

   initial begin
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= REQ_LOAD;
      req_bus.tap_index    <= '0;
      req_bus.coeff_value  <= '0;
      req_bus.sample_value <= '0;
      req_bus.last_sample  <= 1'b0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      foreach (delay_line[j]) delay_line[j] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_length();
      test_single_tap();
      test_full_kernel();
      test_length_limits();
      test_length_change_mid_sequence();
      test_random_sequences();
      finish_phase();

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
